>>> sv/tcfp_pkg.sv
// Shared types and constants for the two-class fragment pool.
// Request and response structs, function and status codes, class sizes.
// No dependencies.
package tcfp_pkg;

    localparam int SMALL_COUNT = 512;
    localparam int LARGE_COUNT = 128;

    localparam int SMALL_IDX_W = (SMALL_COUNT > 1) ? $clog2(SMALL_COUNT) : 1;
    localparam int LARGE_IDX_W = (LARGE_COUNT > 1) ? $clog2(LARGE_COUNT) : 1;
    localparam int SMALL_TOP_W = $clog2(SMALL_COUNT + 1);
    localparam int LARGE_TOP_W = $clog2(LARGE_COUNT + 1);

    localparam int HANDLE_W = 10;
    localparam int BYTES_W  = 16;
    localparam int SPAY_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] FUNC_FETCH = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_BAD_HANDLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_PAYLOAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_PAYLOAD = 1'd1;

    typedef struct packed {
        logic [1:0]          func;
        logic [BYTES_W-1:0]  want_bytes;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [BYTES_W-1:0]  frag_bytes;
        logic [1:0]          status;
    } rsp_t;

    typedef enum logic [1:0] {
        SRC_DIRECT,
        SRC_SMALL_MEM,
        SRC_LARGE_MEM
    } src_t;

endpackage

>>> sv/two_class_fragment_pool.sv
// Two-class fragment pool: small and large LIFO free stacks of fragment handles.
// Depends on tcfp_pkg.
//
// channel   direction  signals                                 handshake
// request   in         start, busy, req                        start & !busy
// response  out        done, rsp                               done (one cycle, no stall)
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data  valid & ready
//
// One request per cycle; each response appears on done in the cycle after its request.
// Stack memories have a registered read; tops update at the accept edge,
// so a following request sees the new top at once. No clearing pass after reset:
// entries below the lowest top reached since reset read as their own index.
// The receiver cannot stall; busy stays low.
module two_class_fragment_pool
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  tcfp_pkg::req_t                      req,
    output logic                                done,
    output tcfp_pkg::rsp_t                      rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcfp_pkg::BYTES_W-1:0]        cfg_data
);

    localparam int SIW = tcfp_pkg::SMALL_IDX_W;
    localparam int LIW = tcfp_pkg::LARGE_IDX_W;
    localparam int STW = tcfp_pkg::SMALL_TOP_W;
    localparam int LTW = tcfp_pkg::LARGE_TOP_W;
    localparam int HW  = tcfp_pkg::HANDLE_W;
    localparam int BW  = tcfp_pkg::BYTES_W;

    logic [SIW-1:0] small_mem [tcfp_pkg::SMALL_COUNT];
    logic [LIW-1:0] large_mem [tcfp_pkg::LARGE_COUNT];

    logic [STW-1:0] small_top_reg, small_top_next;
    logic [STW-1:0] small_low_reg, small_low_next;
    logic [LTW-1:0] large_top_reg, large_top_next;
    logic [LTW-1:0] large_low_reg, large_low_next;

    logic [tcfp_pkg::SPAY_W-1:0] small_payload_reg, small_payload_next;
    logic [BW-1:0]               large_payload_reg, large_payload_next;

    logic            done_reg, done_next;
    tcfp_pkg::src_t  src_reg, src_next;
    tcfp_pkg::rsp_t  base_reg, base_next;
    logic [SIW-1:0]  small_rd_reg;
    logic [LIW-1:0]  large_rd_reg;

    logic            small_rd_en, small_wr_en, large_rd_en, large_wr_en;
    logic [SIW-1:0]  small_rd_addr, small_wr_addr, small_wr_data;
    logic [LIW-1:0]  large_rd_addr, large_wr_addr, large_wr_data;

    logic            accept;
    logic            want_small;
    logic            is_small, is_large;
    logic [STW-1:0]  small_dec;
    logic [LTW-1:0]  large_dec;
    logic [BW-1:0]   small_bytes;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign small_bytes = BW'(small_payload_reg);
    assign want_small  = req.want_bytes <= small_bytes;
    assign is_small    = 32'(req.handle_in) < 32'(tcfp_pkg::SMALL_COUNT);
    assign is_large    = !is_small
                      && (32'(req.handle_in) - 32'(tcfp_pkg::SMALL_COUNT))
                         < 32'(tcfp_pkg::LARGE_COUNT);
    assign small_dec   = small_top_reg - STW'(1);
    assign large_dec   = large_top_reg - LTW'(1);

    always_comb
    begin
        small_top_next     = small_top_reg;
        small_low_next     = small_low_reg;
        large_top_next     = large_top_reg;
        large_low_next     = large_low_reg;
        small_payload_next = small_payload_reg;
        large_payload_next = large_payload_reg;
        done_next          = accept;
        src_next           = tcfp_pkg::SRC_DIRECT;
        base_next          = base_reg;
        small_rd_en        = 1'b0;
        large_rd_en        = 1'b0;
        small_wr_en        = 1'b0;
        large_wr_en        = 1'b0;
        small_rd_addr      = SIW'(small_dec);
        large_rd_addr      = LIW'(large_dec);
        small_wr_addr      = SIW'(small_top_reg);
        large_wr_addr      = LIW'(large_top_reg);
        small_wr_data      = SIW'(req.handle_in);
        large_wr_data      = LIW'(32'(req.handle_in) - 32'(tcfp_pkg::SMALL_COUNT));

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcfp_pkg::CFG_SMALL_PAYLOAD: small_payload_next = cfg_data[tcfp_pkg::SPAY_W-1:0];
                tcfp_pkg::CFG_LARGE_PAYLOAD: large_payload_next = cfg_data;
                default: ;
            endcase
        end

        if (accept)
        begin
            if (req.func == tcfp_pkg::FUNC_FETCH)
            begin
                if (want_small)
                begin
                    base_next.frag_bytes = small_bytes;
                    if (small_top_reg == '0)
                    begin
                        base_next.handle_out = '0;
                        base_next.status     = tcfp_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        small_top_next       = small_dec;
                        base_next.handle_out = HW'(small_dec);
                        base_next.status     = tcfp_pkg::STATUS_OK;
                        if (small_dec >= small_low_reg)
                        begin
                            small_rd_en = 1'b1;
                            src_next    = tcfp_pkg::SRC_SMALL_MEM;
                        end
                        else
                            small_low_next = small_dec;
                    end
                end
                else
                begin
                    base_next.frag_bytes = large_payload_reg;
                    if (large_top_reg == '0)
                    begin
                        base_next.handle_out = '0;
                        base_next.status     = tcfp_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        large_top_next       = large_dec;
                        base_next.handle_out = HW'(32'(tcfp_pkg::SMALL_COUNT) + 32'(large_dec));
                        base_next.status     = tcfp_pkg::STATUS_OK;
                        if (large_dec >= large_low_reg)
                        begin
                            large_rd_en = 1'b1;
                            src_next    = tcfp_pkg::SRC_LARGE_MEM;
                        end
                        else
                            large_low_next = large_dec;
                    end
                end
            end
            else
            begin
                base_next.handle_out = req.handle_in;
                if (is_small)
                begin
                    base_next.frag_bytes = small_bytes;
                    base_next.status     = tcfp_pkg::STATUS_OK;
                    if (req.func == tcfp_pkg::FUNC_FREE
                        && small_top_reg < STW'(tcfp_pkg::SMALL_COUNT))
                    begin
                        small_wr_en    = 1'b1;
                        small_top_next = small_top_reg + STW'(1);
                    end
                end
                else if (is_large)
                begin
                    base_next.frag_bytes = large_payload_reg;
                    base_next.status     = tcfp_pkg::STATUS_OK;
                    if (req.func == tcfp_pkg::FUNC_FREE
                        && large_top_reg < LTW'(tcfp_pkg::LARGE_COUNT))
                    begin
                        large_wr_en    = 1'b1;
                        large_top_next = large_top_reg + LTW'(1);
                    end
                end
                else
                begin
                    base_next.frag_bytes = '0;
                    base_next.status     = tcfp_pkg::STATUS_BAD_HANDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_top_reg     <= STW'(tcfp_pkg::SMALL_COUNT);
            small_low_reg     <= STW'(tcfp_pkg::SMALL_COUNT);
            large_top_reg     <= LTW'(tcfp_pkg::LARGE_COUNT);
            large_low_reg     <= LTW'(tcfp_pkg::LARGE_COUNT);
            small_payload_reg <= tcfp_pkg::SPAY_W'(240);
            large_payload_reg <= BW'(4080);
            done_reg          <= 1'b0;
            src_reg           <= tcfp_pkg::SRC_DIRECT;
        end
        else
        begin
            small_top_reg     <= small_top_next;
            small_low_reg     <= small_low_next;
            large_top_reg     <= large_top_next;
            large_low_reg     <= large_low_next;
            small_payload_reg <= small_payload_next;
            large_payload_reg <= large_payload_next;
            done_reg          <= done_next;
            src_reg           <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
    end

    // stack memories, synchronous read
    always_ff @(posedge clk)
    begin
        if (small_wr_en)
            small_mem[small_wr_addr] <= small_wr_data;
        if (small_rd_en)
            small_rd_reg <= small_mem[small_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (large_wr_en)
            large_mem[large_wr_addr] <= large_wr_data;
        if (large_rd_en)
            large_rd_reg <= large_mem[large_rd_addr];
    end

    always_comb
    begin
        rsp = base_reg;
        case (src_reg)
            tcfp_pkg::SRC_SMALL_MEM: rsp.handle_out = HW'(small_rd_reg);
            tcfp_pkg::SRC_LARGE_MEM:
                rsp.handle_out = HW'(32'(tcfp_pkg::SMALL_COUNT) + 32'(large_rd_reg));
            default: ;
        endcase
    end

    assign done = done_reg;

endmodule
